/* sv/ilist_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the indexed list block.
// Used by the cell, the command decoder, the top level and the checker.
package ilist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [IDX_W-1:0]         t_index;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET      = 3'd0,
        MODE_ADD_HEAD = 3'd1,
        MODE_ADD_TAIL = 3'd2,
        MODE_INSERT   = 3'd3,
        MODE_DELETE   = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    localparam t_word NONE_VALUE = '1;
    localparam t_count CAP_COUNT = CNT_W'(CAPACITY);

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic  insert;
        logic  remove;
        t_pos  pos;
        t_word value;
    } t_cell_ctrl;

    typedef struct packed {
        t_word   read_value;
        logic    found;
        t_status status;
        t_count  entry_count;
    } t_result;

endpackage

/* sv/ilist_cell.sv */
`timescale 1ns / 1ps
// One entry of the list: holds a value and takes its neighbor's value on a shift.
// Depends on ilist_pkg.
module ilist_cell (
    input  logic                i_clk,
    input  ilist_pkg::t_index   i_index,
    input  logic                i_enable,
    input  ilist_pkg::t_cell_ctrl i_ctrl,
    input  ilist_pkg::t_word    i_prev,
    input  ilist_pkg::t_word    i_next,
    output ilist_pkg::t_word    o_entry
);

    ilist_pkg::t_word r_entry;
    ilist_pkg::t_word n_entry;
    ilist_pkg::t_pos  w_index;

    assign w_index = ilist_pkg::POS_W'(i_index);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (w_index == i_ctrl.pos) begin
                n_entry = i_ctrl.value;
            end else if (w_index > i_ctrl.pos) begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.remove) begin
            if (w_index >= i_ctrl.pos) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* sv/ilist_ctrl.sv */
`timescale 1ns / 1ps
// Command decoder: checks range and fullness, drives the cell row and forms the result.
// Depends on ilist_pkg.
module ilist_ctrl (
    input  logic [ilist_pkg::MODE_W-1:0] i_mode,
    input  ilist_pkg::t_pos              i_position,
    input  ilist_pkg::t_word             i_item_value,
    input  ilist_pkg::t_count            i_count,
    input  ilist_pkg::t_word             i_entries [ilist_pkg::CAPACITY],
    output ilist_pkg::t_cell_ctrl        o_ctrl,
    output ilist_pkg::t_result           o_result
);

    logic              w_full;
    logic              w_in_list;
    logic              w_at_or_below_end;
    ilist_pkg::t_count w_next_count;

    assign w_full            = (i_count >= ilist_pkg::CAP_COUNT);
    assign w_in_list         = (ilist_pkg::CNT_W'(i_position) < i_count);
    assign w_at_or_below_end = (ilist_pkg::CNT_W'(i_position) <= i_count);

    always_comb begin
        o_ctrl.insert  = 1'b0;
        o_ctrl.remove  = 1'b0;
        o_ctrl.pos     = i_position;
        o_ctrl.value   = i_item_value;
        o_result.read_value = ilist_pkg::NONE_VALUE;
        o_result.found      = 1'b0;
        o_result.status     = ilist_pkg::STATUS_DONE;
        w_next_count        = i_count;
        unique case (i_mode)
            ilist_pkg::MODE_GET: begin
                if (w_in_list) begin
                    o_result.read_value = i_entries[i_position[ilist_pkg::IDX_W-1:0]];
                    o_result.found      = 1'b1;
                end else begin
                    o_result.status = ilist_pkg::STATUS_RANGE;
                end
            end
            ilist_pkg::MODE_ADD_HEAD, ilist_pkg::MODE_ADD_TAIL: begin
                if (w_full) begin
                    o_result.status = ilist_pkg::STATUS_FULL;
                end else begin
                    o_ctrl.insert = 1'b1;
                    o_ctrl.pos    = (i_mode == ilist_pkg::MODE_ADD_HEAD) ?
                                    '0 : ilist_pkg::POS_W'(i_count);
                    w_next_count  = i_count + ilist_pkg::t_count'(1);
                end
            end
            ilist_pkg::MODE_INSERT: begin
                // The range check takes precedence over the full check.
                if (!w_at_or_below_end) begin
                    o_result.status = ilist_pkg::STATUS_RANGE;
                end else if (w_full) begin
                    o_result.status = ilist_pkg::STATUS_FULL;
                end else begin
                    o_ctrl.insert = 1'b1;
                    w_next_count  = i_count + ilist_pkg::t_count'(1);
                end
            end
            ilist_pkg::MODE_DELETE: begin
                if (w_in_list) begin
                    o_ctrl.remove = 1'b1;
                    w_next_count  = i_count - ilist_pkg::t_count'(1);
                end else begin
                    o_result.status = ilist_pkg::STATUS_RANGE;
                end
            end
            default: begin
            end
        endcase
        o_result.entry_count = w_next_count;
    end

endmodule

/* sv/indexed_list_insert_delete_top.sv */
`timescale 1ns / 1ps
// Top level of the indexed list: a row of entry cells, the command decoder and
// the result register. Depends on ilist_pkg, ilist_cell and ilist_ctrl.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  command | i_valid / o_ready  | i_mode, i_position, i_item_value
//  result  | o_valid / i_ready  | o_read_value, o_found, o_status, o_entry_count
//
// Every command is applied in the cycle it is accepted; one item per clock while results are taken.
// The result appears in the output register in the cycle after acceptance.
// o_ready is high while that register is empty or being taken, so a stalled
// result blocks only the next command. Synchronous reset empties the list;
// entries themselves are not cleared and are never read before being written.
module indexed_list_insert_delete_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ilist_pkg::MODE_W-1:0] i_mode,
    input  logic [ilist_pkg::POS_W-1:0]  i_position,
    input  logic signed [ilist_pkg::DATA_W-1:0] i_item_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ilist_pkg::DATA_W-1:0] o_read_value,
    output logic                         o_found,
    output logic [ilist_pkg::STAT_W-1:0] o_status,
    output logic [ilist_pkg::CNT_W-1:0]  o_entry_count
);

    ilist_pkg::t_word      w_entries [ilist_pkg::CAPACITY];
    ilist_pkg::t_cell_ctrl w_ctrl;
    ilist_pkg::t_result    w_result;
    logic                  w_accept;

    ilist_pkg::t_count  r_count;
    logic               r_out_valid;
    ilist_pkg::t_result r_result;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    ilist_ctrl u_ctrl (
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .i_count      (r_count),
        .i_entries    (w_entries),
        .o_ctrl       (w_ctrl),
        .o_result     (w_result)
    );

    for (genvar g = 0; g < ilist_pkg::CAPACITY; g++) begin : g_cell
        ilist_pkg::t_word w_prev;
        ilist_pkg::t_word w_next;
        // The first cell has no lower neighbor and the last none above.
        if (g == 0) begin : g_first
            assign w_prev = w_ctrl.value;
        end else begin : g_mid_prev
            assign w_prev = w_entries[g-1];
        end
        if (g == ilist_pkg::CAPACITY - 1) begin : g_last
            assign w_next = w_entries[g];
        end else begin : g_mid_next
            assign w_next = w_entries[g+1];
        end
        ilist_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (ilist_pkg::IDX_W'(g)),
            .i_enable (w_accept),
            .i_ctrl   (w_ctrl),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .o_entry  (w_entries[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= w_result.entry_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_result.read_value;
    assign o_found       = r_result.found;
    assign o_status      = r_result.status;
    assign o_entry_count = r_result.entry_count;

endmodule

/* sv/ilist_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the indexed list, bound to the top level.
// Depends on ilist_pkg.
module ilist_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [ilist_pkg::DATA_W-1:0] o_read_value,
    input logic                         o_found,
    input logic [ilist_pkg::STAT_W-1:0] o_status,
    input logic [ilist_pkg::CNT_W-1:0]  o_entry_count
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_value) && $stable(o_status)
                                && $stable(o_entry_count))
        else $error("result changed while stalled");

    // A hit always reports success; a miss always reads as all ones.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == ilist_pkg::STATUS_DONE)
        else $error("found with nonzero status");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_read_value == ilist_pkg::NONE_VALUE)
        else $error("miss without all-ones value");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= ilist_pkg::CAP_COUNT)
        else $error("entry count beyond capacity");

    // An insert refused as full means the list was full when the item came.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ilist_pkg::STATUS_FULL
            |-> o_entry_count == ilist_pkg::CAP_COUNT)
        else $error("full status with list not full");

endmodule

bind indexed_list_insert_delete_top ilist_checker u_ilist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_read_value  (o_read_value),
    .o_found       (o_found),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
